// ----- hw/rtl/dtr_pkg.sv -----
// ----------------------------------------------------------------------------
// dtr_pkg
// shared types and constants of the table-driven recognizer
// ----------------------------------------------------------------------------
package dtr_pkg;

    // field widths of the stream items
    localparam int OPCODE_W  = 3;
    localparam int SYMBOL_W  = 8;
    localparam int SRC_W     = 6;
    localparam int STATE_W   = 7;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    // marks an undefined transition or a blocked run
    localparam logic [STATE_W-1:0] UNDEF_STATE = 7'h7F;

    // register index taken from paddr[2]
    localparam logic REG_NUM_STATES = 1'b0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_WRITE = 3'd1,
        OP_MARK  = 3'd2,
        OP_FEED  = 3'd3,
        OP_END   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } fsm_t;

endpackage

// ----- hw/rtl/dfa_table_recognizer_unit.sv -----
// ----------------------------------------------------------------------------
// dfa_table_recognizer_unit
// deterministic finite automaton with a loadable transition table in memory
// ----------------------------------------------------------------------------
// a result is registered: the item is held in the execute stage and finishes into the
//   output register once the output slot is free; throughput: one item per cycle while
//   results are taken, set by the registered read of the transition memory and the run state write-back
// a clear item sweeps the whole table, one entry per cycle, and no item is
//   taken during the sweep
// reset: run state 0, no final marks, then the same sweep before the first item

module dfa_table_recognizer_unit #(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // item stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // symbol[7:0], src_state[13:8], dst_state[20:14]
    input  logic [2:0]  s_tuser,   // opcode[2:0]

    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[0], accepted[1], current_state[8:2]

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ST_W   = $clog2(MAX_STATES);
    localparam int SYM_W  = $clog2(ALPHABET_SIZE);
    localparam int ADDR_W = ST_W + SYM_W;
    localparam int DEPTH  = MAX_STATES * (1 << SYM_W);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [8:0] MAX_N   = 9'(MAX_STATES);
    localparam logic [8:0] ALPHA_N = 9'(ALPHABET_SIZE);

    // ------------------------------------------------------------------
    // stored state
    // ------------------------------------------------------------------
    dtr_pkg::fsm_t     state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [6:0]        run_reg, run_next;
    logic [6:0]        num_states_reg;
    logic [MAX_STATES-1:0] fin_reg, fin_next;

    // item held while it executes
    dtr_pkg::op_t      op_reg;
    logic [7:0]        sym_reg;
    logic [5:0]        src_reg;
    logic [6:0]        dst_reg;

    // output register
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    // transition memory, read data registered
    logic [6:0]        tbl_mem [DEPTH];
    logic [6:0]        rd_data_reg;
    logic              fwd_hit_reg;
    logic [6:0]        fwd_data_reg;

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    dtr_pkg::op_t in_op;
    logic [7:0]   in_sym;
    logic [5:0]   in_src;
    logic [6:0]   in_dst;

    assign in_op  = dtr_pkg::op_t'(s_tuser);
    assign in_sym = s_tdata[7:0];
    assign in_src = s_tdata[13:8];
    assign in_dst = s_tdata[20:14];

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dtr_pkg::REG_NUM_STATES) ? {25'b0, num_states_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= 7'b0;
        end
        else if (cfg_wr && paddr[2] == dtr_pkg::REG_NUM_STATES)
        begin
            num_states_reg <= pwdata[6:0];
        end
    end

    // states in use, capped at the table size
    logic [8:0] n_eff;
    assign n_eff = ({2'b0, num_states_reg} > MAX_N) ? MAX_N : {2'b0, num_states_reg};

    // ------------------------------------------------------------------
    // execute stage: finishes the held item when the output slot is free
    // ------------------------------------------------------------------
    logic             out_free;
    logic             finish;
    logic [6:0]       lookup;
    logic             run_ok;
    logic             sym_ok;
    logic             wr_ok;
    logic             mark_ok;
    logic [ST_W-1:0]  run_idx;
    logic [ST_W-1:0]  src_idx;
    logic             res_status;
    logic             res_accepted;
    logic [6:0]       res_shown;
    logic [6:0]       run_after;

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == dtr_pkg::ST_EXEC) && out_free;

    // a write in the cycle of the read overrides the stale read data
    assign lookup   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    assign run_ok   = !run_reg[6] && ({2'b0, run_reg} < MAX_N);
    assign sym_ok   = ({1'b0, sym_reg} < ALPHA_N);
    assign run_idx  = ST_W'(run_reg[5:0]);
    assign src_idx  = ST_W'(src_reg);

    // dst may be undefined, any other negative code is rejected
    assign wr_ok    = ({3'b0, src_reg} < n_eff)
                   && (!dst_reg[6] || dst_reg == dtr_pkg::UNDEF_STATE)
                   && (dst_reg[6] || ({2'b0, dst_reg} < n_eff))
                   && sym_ok;
    assign mark_ok  = ({3'b0, src_reg} < n_eff);

    always_comb
    begin
        res_status   = 1'b0;
        res_accepted = 1'b0;
        res_shown    = run_reg;
        run_after    = run_reg;
        case (op_reg)
            dtr_pkg::OP_CLEAR:
            begin
                run_after = 7'b0;
                res_shown = 7'b0;
            end
            dtr_pkg::OP_WRITE:
            begin
                res_status = !wr_ok;
            end
            dtr_pkg::OP_MARK:
            begin
                res_status = !mark_ok;
            end
            dtr_pkg::OP_FEED:
            begin
                // blocked runs and symbols outside the alphabet stay blocked
                run_after = (run_ok && sym_ok) ? lookup : dtr_pkg::UNDEF_STATE;
                res_shown = run_after;
            end
            dtr_pkg::OP_END:
            begin
                res_accepted = run_ok && fin_reg[run_idx];
                run_after    = 7'b0;
            end
            default:
            begin
                res_status = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // acceptance and memory addressing
    // ------------------------------------------------------------------
    logic              acc;
    logic [6:0]        base_run;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [6:0]        mem_wdata;

    // a new item may enter in the cycle the previous one finishes
    assign s_tready = (state_reg == dtr_pkg::ST_IDLE)
                   || (finish && op_reg != dtr_pkg::OP_CLEAR);
    assign acc      = s_tvalid && s_tready;

    // read the entry for the run state as it stands after the finishing item
    assign base_run = (state_reg == dtr_pkg::ST_EXEC) ? run_after : run_reg;
    assign rd_addr  = {ST_W'(base_run[5:0]), in_sym[SYM_W-1:0]};

    always_comb
    begin
        if (state_reg == dtr_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = dtr_pkg::UNDEF_STATE;
        end
        else
        begin
            mem_we    = finish && op_reg == dtr_pkg::OP_WRITE && wr_ok;
            mem_waddr = {src_idx, sym_reg[SYM_W-1:0]};
            mem_wdata = dst_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (acc)
        begin
            rd_data_reg  <= tbl_mem[rd_addr];
            fwd_hit_reg  <= mem_we && (mem_waddr == rd_addr);
            fwd_data_reg <= mem_wdata;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg  <= in_op;
            sym_reg <= in_sym;
            src_reg <= in_src;
            dst_reg <= in_dst;
        end
    end

    // ------------------------------------------------------------------
    // control: clear sweep, idle, execute
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            dtr_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = dtr_pkg::ST_IDLE;
                end
            end
            dtr_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = dtr_pkg::ST_EXEC;
                end
            end
            dtr_pkg::ST_EXEC:
            begin
                if (finish)
                begin
                    if (op_reg == dtr_pkg::OP_CLEAR)
                    begin
                        state_next   = dtr_pkg::ST_CLEAR;
                        clr_cnt_next = '0;
                    end
                    else if (!acc)
                    begin
                        state_next = dtr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dtr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        run_next = finish ? run_after : run_reg;
        fin_next = fin_reg;
        if (finish && op_reg == dtr_pkg::OP_CLEAR)
        begin
            fin_next = '0;
        end
        else if (finish && op_reg == dtr_pkg::OP_MARK && mark_ok)
        begin
            fin_next[src_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dtr_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            run_reg     <= 7'b0;
            fin_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            run_reg     <= run_next;
            fin_reg     <= fin_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: one result transfer per item
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_tdata_reg <= {7'b0, res_shown, res_accepted, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the table-driven recognizer: loads transition
// tables and final marks, feeds words, and checks every result against a
// behavioral predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------

import dtr_pkg::*;

// result word as it leaves on m_tdata, lowest bit last
typedef struct packed {
    logic [6:0]         pad;
    logic [STATE_W-1:0] state;
    logic               accepted;
    logic               status;
} dfa_result_t;

class dfa_scoreboard;
    localparam int DFA_STATES  = 64;
    localparam int DFA_SYMBOLS = 256;

    logic [STATE_W-1:0]        trans_mem [DFA_STATES*DFA_SYMBOLS];
    bit                        final_mark [DFA_STATES];
    logic signed [STATE_W-1:0] run_state;
    int unsigned               num_states;
    dfa_result_t               expected_q [$];
    int errors, n_items, n_results, n_words, n_accepted, n_clears;

    function new();
        wipe();
        num_states = 0;
    endfunction

    function void wipe();
        foreach (trans_mem[i]) trans_mem[i] = UNDEF_STATE;
        foreach (final_mark[i]) final_mark[i] = 1'b0;
        run_state = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // advance the automaton by one accepted item and queue its result
    function void note_item(logic [OPCODE_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                            logic [SRC_W-1:0] src, logic signed [STATE_W-1:0] dst);
        dfa_result_t exp_res;
        int n, d, s;
        n = (num_states > DFA_STATES) ? DFA_STATES : num_states;
        d = dst;
        s = src;
        exp_res = '0;
        n_items++;
        case (op)
            OP_CLEAR:
            begin
                wipe();
                n_clears++;
            end
            OP_WRITE:
            begin
                if (s >= n || d < -1 || d >= n)
                    exp_res.status = 1'b1;
                else
                    trans_mem[s*DFA_SYMBOLS + sym] = dst;
            end
            OP_MARK:
            begin
                if (s >= n)
                    exp_res.status = 1'b1;
                else
                    final_mark[s] = 1'b1;
            end
            OP_FEED:
            begin
                if (run_state >= 0)
                    run_state = trans_mem[int'(run_state)*DFA_SYMBOLS + sym];
                else
                    run_state = UNDEF_STATE;
            end
            OP_END: ;
            default: exp_res.status = 1'b1;
        endcase
        exp_res.state = run_state;
        if (op == OP_END)
        begin
            n_words++;
            if (run_state >= 0 && final_mark[run_state])
            begin
                exp_res.accepted = 1'b1;
                n_accepted++;
            end
            run_state = '0;
        end
        expected_q.push_back(exp_res);
    endfunction

    function void cmp_field(string name, logic [6:0] exp_val, logic [6:0] got_val);
        if (got_val !== exp_val)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
        end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
        dfa_result_t got, exp_res;
        got = data;
        n_results++;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t ns: result with nothing expected, expected none, actual %h",
                     $time, data);
            return;
        end
        exp_res = expected_q.pop_front();
        cmp_field("status", exp_res.status, got.status);
        cmp_field("accepted", exp_res.accepted, got.accepted);
        cmp_field("current_state", exp_res.state, got.state);
        cmp_field("padding", exp_res.pad, got.pad);
    endfunction
endclass

module tb_top;

    // opcodes the block does not define
    localparam logic [OPCODE_W-1:0] OP_RSV_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSV_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSV_C = 3'd7;

    // longest stretch with no transfer, long enough for a whole clear sweep
    localparam int STALL_LIMIT = 60000;
    localparam int PHASE_ITEMS = 190;
    localparam int NUM_PHASES  = 8;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // symbol[7:0], src_state[13:8], dst_state[20:14]
    logic [2:0]  s_tuser;   // opcode[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status[0], accepted[1], current_state[8:2]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dfa_scoreboard sb = new();

    // symbols that the current phase mostly works with
    logic [SYMBOL_W-1:0] sym_set [4];
    // stretches with no idling on either side
    bit src_calm;
    bit snk_calm;
    int idle_cycles;

    dfa_table_recognizer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // switch idling off now and then for a while
    initial
    begin
        src_calm = 1'b0;
        snk_calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 300)) @(posedge clk);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog: any transfer on either stream or the register port restarts it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stall before each result, then take it and check it
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // one item transfer, after a random gap with tvalid low
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                             input logic [SRC_W-1:0] src, input logic [STATE_W-1:0] dst);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, dst, src, sym};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, sym, src, dst);
    endtask

    // any opcode but clear, every field fully random
    task automatic send_noise();
        send_item(3'($urandom_range(OP_WRITE, OP_RSV_C)), 8'($urandom),
                  6'($urandom), 7'($urandom));
    endtask

    // setup cycle then access cycle; pready is always high
    task automatic reg_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_NUM_STATES, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block idle: no result outstanding and the clear sweep finished
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
        do @(posedge clk); while (!s_tready);
    endtask

    // write num_states, upper bits of the bus random, then read it back
    task automatic set_states(input logic [6:0] value);
        logic [31:0] rd;
        wait_idle();
        reg_access(1'b1, {25'($urandom), value}, rd);
        sb.num_states = value;
        @(posedge clk);
        reg_access(1'b0, '0, rd);
        if (rd[6:0] !== value)
        begin
            sb.errors++;
            $display("%0t ns: num_states readback mismatch, expected %0h, actual %0h",
                     $time, value, rd[6:0]);
        end
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_sym();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return sym_set[$urandom_range(0, 3)];
    endfunction

    // mostly states in use, sometimes any state
    function automatic logic [SRC_W-1:0] pick_src(input int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return 6'($urandom);
        return 6'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [STATE_W-1:0] pick_dst(input int n);
        if (n == 0 || $urandom_range(0, 5) == 0)
            return UNDEF_STATE;
        return 7'($urandom_range(0, n - 1));
    endfunction

    // one random setting: table load, final marks, then words until the budget
    task automatic run_phase(input logic [6:0] cfg, input bit do_clear);
        int n, target, len;
        n = (cfg > 64) ? 64 : cfg;
        set_states(cfg);
        if (do_clear)
            send_item(OP_CLEAR, 8'($urandom), 6'($urandom), 7'($urandom));
        for (int k = 0; k < 4; k++)
            sym_set[k] = 8'($urandom);
        target = sb.n_items + PHASE_ITEMS;
        repeat ((n >= 16) ? 64 : 4 * n + 4)
            send_item(OP_WRITE, pick_sym(), pick_src(n), pick_dst(n));
        repeat (n / 3 + 2)
            send_item(OP_MARK, 8'($urandom), pick_src(n), 7'($urandom));
        while (sb.n_items < target)
        begin
            len = $urandom_range(0, 8);
            repeat (len)
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_item(OP_FEED, pick_sym(), 6'($urandom), 7'($urandom));
            send_item(OP_END, 8'($urandom), 6'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        logic [6:0] cfg;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // oversized register acts as the full 64 states
        set_states(7'd127);
        send_item(OP_WRITE, 8'd255, 6'd63, 7'd63);
        send_item(OP_WRITE, 8'd0, 6'd0, 7'd1);
        send_item(OP_WRITE, 8'd0, 6'd1, UNDEF_STATE);
        // destinations below undefined are rejected
        send_item(OP_WRITE, 8'd3, 6'd0, 7'h7E);
        send_item(OP_WRITE, 8'd3, 6'd0, 7'h40);
        send_item(OP_MARK, 8'd0, 6'd63, 7'd0);
        send_item(OP_MARK, 8'd0, 6'd1, 7'd0);
        send_item(OP_FEED, 8'd0, 6'd0, 7'd0);
        send_item(OP_END, 8'd0, 6'd0, 7'd0);
        // undefined transition blocks, feeding while blocked stays blocked
        send_item(OP_FEED, 8'd5, 6'd0, 7'd0);
        send_item(OP_FEED, 8'd0, 6'd0, 7'd0);
        send_item(OP_END, 8'd0, 6'd0, 7'd0);
        send_item(OP_RSV_A, 8'hAA, 6'h2A, 7'h55);
        send_item(OP_RSV_B, 8'h55, 6'h15, 7'h2A);
        send_item(OP_RSV_C, 8'hFF, 6'h3F, 7'h7F);
        send_item(OP_END, 8'd0, 6'd0, 7'd0);

        // one state: anything past state 0 is out of range
        set_states(7'd1);
        send_item(OP_WRITE, 8'd7, 6'd1, 7'd0);
        send_item(OP_MARK, 8'd0, 6'd1, 7'd0);
        send_item(OP_WRITE, 8'd7, 6'd0, 7'd0);
        send_item(OP_WRITE, 8'd7, 6'd0, 7'd1);
        send_item(OP_MARK, 8'd0, 6'd0, 7'd0);

        // no states: marks fail, but the table keeps its entries
        set_states(7'd0);
        send_item(OP_MARK, 8'd0, 6'd0, 7'd0);
        send_item(OP_FEED, 8'd7, 6'd0, 7'd0);
        send_item(OP_END, 8'd0, 6'd0, 7'd0);
        send_item(OP_CLEAR, 8'hFF, 6'h3F, 7'h7F);
        send_item(OP_END, 8'd0, 6'd0, 7'd0);

        // random settings, first one at the full state count
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0: cfg = 7'd0;
                1: cfg = 7'd1;
                2: cfg = 7'd64;
                3: cfg = 7'($urandom_range(65, 127));
                default: cfg = 7'($urandom_range(2, 12));
            endcase
            if (p == 0)
                cfg = 7'd64;
            run_phase(cfg, (p == 0) || ($urandom_range(0, 1) == 0));
        end

        // drain and let any stray result show up
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (16) @(posedge clk);

        $display("run covered %0d items and %0d results, %0d clears", sb.n_items,
                 sb.n_results, sb.n_clears);
        $display("%0d words ended, %0d accepted, %0d errors", sb.n_words,
                 sb.n_accepted, sb.errors);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dtr_pkg.sv
hw/rtl/dfa_table_recognizer_unit.sv
verif/tb_top.sv
